FILE: rtl/core/stinv_pkg.sv
package stinv_pkg;

  // component and datapath widths
  localparam int NCOMP   = 9;
  localparam int COMP_W  = 32;
  localparam int IN_W    = NCOMP * COMP_W;
  localparam int D_W     = COMP_W + 3;       // doubled tensor terms and their differences
  localparam int OP_W    = COMP_W + 2;       // squarer operand (magnitude)
  localparam int SQ_W    = 2 * OP_W;         // square and radicand width
  localparam int GRP_W   = SQ_W + 2;         // sum of three squares
  localparam int TOT_W   = SQ_W + 4;         // weighted total before scaling
  localparam int ROOT_W  = OP_W;
  localparam int REM_W   = OP_W + 2;
  localparam int VAL_W   = 48;
  localparam int PU_W    = 35;               // biased negated trace
  localparam int PROD_W  = 2 * PU_W;
  localparam int PQ_W    = PROD_W - 36;      // quotient bits

  // floor(u/3) = (u * RECIP_3) >> 36, exact for u < 2**35
  localparam int RECIP_SHIFT = 36;
  localparam logic [PU_W-1:0] RECIP_3      = 35'd22906492246;
  localparam logic signed [PU_W:0] PRES_BIAS = 36'sd25769803776; // 3 * 2**33
  localparam logic signed [PU_W:0] PRES_UNBIAS = 36'sd8589934592; // 2**33

  // field kinds
  localparam logic [2:0] KIND_SCALAR = 3'd0;
  localparam logic [2:0] KIND_VECTOR = 3'd1;
  localparam logic [2:0] KIND_SYM3D  = 3'd2;
  localparam logic [2:0] KIND_SYM2D  = 3'd3;
  localparam logic [2:0] KIND_FULL3D = 3'd4;

  // result selects
  localparam logic [1:0] SEL_COMP = 2'd0;
  localparam logic [1:0] SEL_MAG  = 2'd1;
  localparam logic [1:0] SEL_VM   = 2'd2;
  localparam logic [1:0] SEL_PRES = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BADINV = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // register indexes
  localparam logic [2:0] REG_FIELD_KIND  = 3'd0;
  localparam logic [2:0] REG_RESULT_SEL  = 3'd1;
  localparam logic [2:0] REG_COMP_PICK   = 3'd2;
  localparam logic [2:0] REG_VEC_WIDTH   = 3'd3;
  localparam logic [2:0] REG_ENABLES     = 3'd4;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] sel;
    logic [3:0] pick;
    logic [3:0] vwidth;
    logic [2:0] enables;
  } cfg_t;

  typedef struct packed {
    logic             use_root;
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [NCOMP-1:0][OP_W-1:0] ops;
    logic                       vm;
    logic                       pres;
    logic [PU_W-1:0]            pu;
    side_t                      side;
  } front_t;

endpackage

FILE: rtl/core/stinv_front.sv
module stinv_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [stinv_pkg::IN_W-1:0] comps,
  input  logic                     in_last,
  input  stinv_pkg::cfg_t          cfg,
  output logic                     out_valid,
  output stinv_pkg::front_t        out
);

  stinv_pkg::front_t f_next;

  function automatic logic [stinv_pkg::OP_W-1:0] absd(
    input logic signed [stinv_pkg::D_W-1:0] x
  );
    logic signed [stinv_pkg::D_W-1:0] m;
    m = (x < 0) ? -x : x;
    return m[stinv_pkg::OP_W-1:0];
  endfunction

  // decode field kind and mode, form squarer operands
  always_comb begin
    logic signed [stinv_pkg::COMP_W-1:0] c [stinv_pkg::NCOMP];
    logic signed [stinv_pkg::D_W-1:0] ce [stinv_pkg::NCOMP];
    logic signed [stinv_pkg::D_W-1:0] d11, d22, d33, d12, d13, d23;
    logic signed [stinv_pkg::PU_W:0] tr;
    logic [3:0] vw;
    logic [3:0] count;
    logic       tensor;
    logic       kind_ok;
    logic signed [stinv_pkg::COMP_W-1:0] picked;

    for (int i = 0; i < stinv_pkg::NCOMP; i++) begin
      c[i]  = comps[i*stinv_pkg::COMP_W +: stinv_pkg::COMP_W];
      ce[i] = stinv_pkg::D_W'(c[i]);
    end
    vw = (cfg.vwidth > 4'(stinv_pkg::NCOMP)) ? 4'(stinv_pkg::NCOMP) : cfg.vwidth;
    tensor = (cfg.kind == stinv_pkg::KIND_SYM3D) || (cfg.kind == stinv_pkg::KIND_SYM2D) ||
             (cfg.kind == stinv_pkg::KIND_FULL3D);

    // doubled tensor terms
    if (cfg.kind == stinv_pkg::KIND_FULL3D) begin
      d11 = ce[0] <<< 1; d22 = ce[4] <<< 1; d33 = ce[8] <<< 1;
      d12 = ce[1] + ce[3]; d13 = ce[2] + ce[6]; d23 = ce[5] + ce[7];
      tr  = stinv_pkg::PU_W'(ce[0] + ce[4] + ce[8]);
    end else begin
      d11 = ce[0] <<< 1; d22 = ce[1] <<< 1; d33 = ce[2] <<< 1;
      d12 = ce[3] <<< 1;
      d13 = (cfg.kind == stinv_pkg::KIND_SYM3D) ? (ce[4] <<< 1) : '0;
      d23 = (cfg.kind == stinv_pkg::KIND_SYM3D) ? (ce[5] <<< 1) : '0;
      tr  = stinv_pkg::PU_W'(ce[0] + ce[1] + ce[2]);
    end

    // component count for extract mode
    kind_ok = 1'b1;
    case (cfg.kind)
      stinv_pkg::KIND_SCALAR: count = 4'd1;
      stinv_pkg::KIND_VECTOR: count = vw;
      stinv_pkg::KIND_SYM3D:  count = 4'd6;
      stinv_pkg::KIND_SYM2D:  count = 4'd4;
      stinv_pkg::KIND_FULL3D: count = 4'd9;
      default: begin
        count   = 4'd0;
        kind_ok = 1'b0;
      end
    endcase
    picked = '0;
    for (int i = 0; i < stinv_pkg::NCOMP; i++) begin
      if (cfg.pick == 4'(i)) picked = c[i];
    end

    f_next               = '0;
    f_next.side.last     = in_last;
    f_next.pu            = stinv_pkg::PU_W'(stinv_pkg::PRES_BIAS - tr);
    case (cfg.sel)
      stinv_pkg::SEL_COMP: begin
        if (!kind_ok) begin
          f_next.side.status = stinv_pkg::ST_BADINV;
        end else if (cfg.pick >= count) begin
          f_next.side.status = stinv_pkg::ST_RANGE;
        end else begin
          f_next.side.value = stinv_pkg::VAL_W'(picked);
        end
      end
      stinv_pkg::SEL_MAG: begin
        f_next.side.use_root = 1'b1;
        if (!cfg.enables[0] || cfg.kind != stinv_pkg::KIND_VECTOR) begin
          f_next.side.status = stinv_pkg::ST_BADINV;
        end else begin
          for (int i = 0; i < stinv_pkg::NCOMP; i++) begin
            if (4'(i) < vw) f_next.ops[i] = absd(ce[i]);
          end
        end
      end
      stinv_pkg::SEL_VM: begin
        f_next.side.use_root = 1'b1;
        if (!cfg.enables[1] || !tensor) begin
          f_next.side.status = stinv_pkg::ST_BADINV;
        end else begin
          f_next.vm     = 1'b1;
          f_next.ops[0] = absd(d11 - d22);
          f_next.ops[1] = absd(d22 - d33);
          f_next.ops[2] = absd(d33 - d11);
          f_next.ops[3] = absd(d12);
          f_next.ops[4] = absd(d13);
          f_next.ops[5] = absd(d23);
        end
      end
      stinv_pkg::SEL_PRES: begin
        if (!cfg.enables[2] || !tensor) begin
          f_next.side.status = stinv_pkg::ST_BADINV;
        end else begin
          f_next.pres = 1'b1;
        end
      end
      default: f_next.side.status = stinv_pkg::ST_BADINV;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out <= f_next;
    end
  end

endmodule

FILE: rtl/core/stinv_square.sv
module stinv_square (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  stinv_pkg::front_t         in,
  output logic                      out_valid,
  output logic [stinv_pkg::SQ_W-1:0] rad,
  output stinv_pkg::side_t          out_side
);

  // stage 2: squares and pressure product
  logic [stinv_pkg::SQ_W-1:0]   sq [stinv_pkg::NCOMP];
  logic [stinv_pkg::PROD_W-1:0] prod;
  logic                         vm2, pres2, v2;
  stinv_pkg::side_t             side2;
  stinv_pkg::side_t             side2_next;

  // stage 3: group sums, pressure finished
  logic [stinv_pkg::GRP_W-1:0]  grp [3];
  logic                         vm3, v3;
  stinv_pkg::side_t             side3;

  logic [stinv_pkg::TOT_W-1:0]  total;
  logic signed [stinv_pkg::PU_W:0] pq;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < stinv_pkg::NCOMP; i++) begin
        sq[i] <= in.ops[i] * in.ops[i];
      end
      prod  <= in.pu * stinv_pkg::RECIP_3;
      vm2   <= in.vm;
      pres2 <= in.pres;
      side2 <= in.side;
    end
  end

  assign pq = $signed({2'b00, prod[stinv_pkg::PROD_W-1:stinv_pkg::RECIP_SHIFT]}) -
              stinv_pkg::PRES_UNBIAS;

  // pressure result replaces the side value
  always_comb begin
    side2_next = side2;
    if (pres2) side2_next.value = stinv_pkg::VAL_W'(pq);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < 3; g++) begin
        grp[g] <= stinv_pkg::GRP_W'(sq[3*g]) + stinv_pkg::GRP_W'(sq[3*g+1]) +
                  stinv_pkg::GRP_W'(sq[3*g+2]);
      end
      vm3   <= vm2;
      side3 <= side2_next;
    end
  end

  // weighted total: squared von Mises is (normal + 6*shear) / 8 in doubled units, else the sum of all squares
  always_comb begin
    if (vm3) begin
      total = (stinv_pkg::TOT_W'(grp[0]) + (stinv_pkg::TOT_W'(grp[1]) << 1) +
               (stinv_pkg::TOT_W'(grp[1]) << 2)) >> 3;
    end else begin
      total = stinv_pkg::TOT_W'(grp[0]) + stinv_pkg::TOT_W'(grp[1]) +
              stinv_pkg::TOT_W'(grp[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad      <= total[stinv_pkg::SQ_W-1:0];
      out_side <= side3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= in_valid;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

FILE: rtl/core/stinv_sqrt.sv
module stinv_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [stinv_pkg::SQ_W-1:0] rad_in,
  input  stinv_pkg::side_t           in_side,
  output logic                       out_valid,
  output logic [stinv_pkg::VAL_W-1:0] value,
  output logic [1:0]                 status,
  output logic                       last
);

  localparam int N = stinv_pkg::ROOT_W;

  logic                          vld  [N+1];
  logic [stinv_pkg::SQ_W-1:0]    rad  [N+1];
  logic [stinv_pkg::REM_W-1:0]   rem  [N+1];
  logic [stinv_pkg::ROOT_W-1:0]  root [N+1];
  stinv_pkg::side_t              side [N+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = rad_in;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  // one root bit per stage, restoring digit recurrence
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [stinv_pkg::REM_W-1:0] rem_sh, trial;
    logic                        take;

    always_comb begin
      rem_sh = {rem[k][stinv_pkg::OP_W-1:0], rad[k][stinv_pkg::SQ_W-1 -: 2]};
      trial  = {root[k], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        root[k+1] <= {root[k][stinv_pkg::ROOT_W-2:0], take};
        side[k+1] <= side[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign value     = side[N].use_root ? stinv_pkg::VAL_W'(root[N]) : side[N].value;
  assign status    = side[N].status;
  assign last      = side[N].last;

endmodule

FILE: rtl/core/stress_tensor_invariants.sv
// Stress invariants over a stream of result tuples: each tuple of nine Q16.16
// components gives one Q32.16 result (component, vector magnitude, von Mises or
// pressure, per the configuration registers). One tuple is taken every cycle
// while the pipeline advances; each tuple passes through one decode stage, three
// stages of squaring and summing, and a 34-stage square root that yields one
// root bit per stage. The whole pipeline advances together whenever the output
// register is empty or being taken, so a stall on the master side holds every
// stage. Configuration writes must be made only while no transaction is in flight.
module stress_tensor_invariants (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [3:0]                   cfg_wdata,
  // input tuples
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [stinv_pkg::IN_W-1:0]   s_tdata,  // comp0 .. comp8, 32 bits each
  input  logic                         s_tlast,  // tuple_last
  // results
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [stinv_pkg::VAL_W-1:0]  m_tdata,  // result_value
  output logic [1:0]                   m_tuser,  // result_status
  output logic                         m_tlast   // result_last
);

  stinv_pkg::cfg_t   cfg;
  logic              en;
  logic              f_valid, q_valid;
  stinv_pkg::front_t f_out;
  logic [stinv_pkg::SQ_W-1:0] q_rad;
  stinv_pkg::side_t  q_side;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind    <= stinv_pkg::KIND_SYM3D;
      cfg.sel     <= stinv_pkg::SEL_VM;
      cfg.pick    <= 4'd0;
      cfg.vwidth  <= 4'd3;
      cfg.enables <= 3'd6;
    end else if (cfg_we) begin
      case (cfg_addr)
        stinv_pkg::REG_FIELD_KIND: cfg.kind    <= cfg_wdata[2:0];
        stinv_pkg::REG_RESULT_SEL: cfg.sel     <= cfg_wdata[1:0];
        stinv_pkg::REG_COMP_PICK:  cfg.pick    <= cfg_wdata;
        stinv_pkg::REG_VEC_WIDTH:  cfg.vwidth  <= cfg_wdata;
        stinv_pkg::REG_ENABLES:    cfg.enables <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // global advance
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  stinv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .comps     (s_tdata),
    .in_last   (s_tlast),
    .cfg       (cfg),
    .out_valid (f_valid),
    .out       (f_out)
  );

  stinv_square u_square (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in        (f_out),
    .out_valid (q_valid),
    .rad       (q_rad),
    .out_side  (q_side)
  );

  stinv_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (q_valid),
    .rad_in    (q_rad),
    .in_side   (q_side),
    .out_valid (m_tvalid),
    .value     (m_tdata),
    .status    (m_tuser),
    .last      (m_tlast)
  );

endmodule
